>>> design/segregated_fit_offset_allocator_macros.svh
// Assertion macros used by the allocator checker.
`ifndef SEGREGATED_FIT_OFFSET_ALLOCATOR_MACROS_SVH
`define SEGREGATED_FIT_OFFSET_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SFOA_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("allocator assertion failed");

// Next-cycle implication, disabled during reset.
`define SFOA_ASSERT_NXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("allocator assertion failed");

`endif

>>> design/sfoa_pkg.sv
// Shared widths, codes and the size-class function of the offset allocator.
package sfoa_pkg;

  localparam int OP_W     = 2;
  localparam int STAT_W   = 2;
  localparam int UNIT_W   = 32;
  localparam int HANDLE_W = 10;
  localparam int BIN_W    = 8;
  localparam int MANT_W   = 3;
  localparam int TOP_BINS = 32;

  localparam logic [UNIT_W-1:0] POOL_RESET = 32'd1048576;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC  = 2'd0,
    OP_FREE   = 2'd1,
    OP_REINIT = 2'd2,
    OP_NONE   = 2'd3
  } opcode_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 2'd0,
    ST_NO_NODES = 2'd1,
    ST_NO_SPACE = 2'd2,
    ST_UNUSED   = 2'd3
  } status_t;

  function automatic logic [BIN_W-1:0] code_of(input logic [UNIT_W-1:0] sz, input logic up);
    logic [4:0]        hb;
    logic [4:0]        st;
    logic [3:0]        mant;
    logic [UNIT_W-1:0] lowm;
    logic [BIN_W-1:0]  res;
    hb = '0;
    for (int i = 0; i < UNIT_W; i++) begin
      if (sz[i]) hb = 5'(i);
    end
    st   = hb - 5'd3;
    mant = {1'b0, 3'(sz >> st)};
    lowm = (32'd1 << st) - 32'd1;
    if (up && ((sz & lowm) != 32'd0)) mant = mant + 4'd1;
    res = {st + 5'd1, 3'b000} + {4'b0000, mant};
    if (sz < 32'd8) res = sz[BIN_W-1:0];
    return res;
  endfunction

endpackage

>>> design/sfoa_if.sv
// Request and result channel interfaces of the offset allocator.
interface sfoa_in_if import sfoa_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     opcode;
  logic [UNIT_W-1:0]   req_size;
  logic [HANDLE_W-1:0] handle;
  modport source (output valid, opcode, req_size, handle, input ready);
  modport sink (input valid, opcode, req_size, handle, output ready);
endinterface

interface sfoa_out_if import sfoa_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STAT_W-1:0]   status;
  logic [UNIT_W-1:0]   offset;
  logic [HANDLE_W-1:0] alloc_handle;
  logic [UNIT_W-1:0]   free_total;
  modport source (output valid, status, offset, alloc_handle, free_total, input ready);
  modport sink (input valid, status, offset, alloc_handle, free_total, output ready);
endinterface

>>> design/sfoa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sfoa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

>>> design/segregated_fit_offset_allocator.sv
// Two-level segregated-fit offset allocator: top level and sequencer.
//
// Requests arrive on in_ch (opcode, req_size, handle), one result per request
// leaves on out_ch (status, offset, alloc_handle, free_total). A beat moves on
// a channel when valid and ready are both high. in_ch.ready is high only while
// the sequencer is idle; one request is worked on at a time.
// The sequencer walks the node RAMs for each request; reinit sweeps
// max(MAX_NODES, 256) table rows, one table row written per cycle.
// The result sits in an output register; a new request is taken while it
// waits, and the next result waits in the final state until out_ch is free.
// pool_size is written through cfg_we/cfg_data and is used at reset and reinit.
// Reset (rst, synchronous) loads pool_size = 1048576 and runs the same table
// sweep as reinit, with no result and in_ch not ready; configuration writes
// are taken throughout.
module segregated_fit_offset_allocator import sfoa_pkg::*; #(
  parameter int MAX_NODES = 1024
) (
  input  logic          clk,
  input  logic          rst,
  sfoa_in_if.sink       in_ch,
  sfoa_out_if.source    out_ch,
  input  logic          cfg_we,
  input  logic [UNIT_W-1:0] cfg_data
);
  localparam int NW    = $clog2(MAX_NODES);
  localparam int LW    = NW + 1;
  localparam int SWEEP = (MAX_NODES > 256) ? MAX_NODES : 256;
  localparam int CW    = $clog2(SWEEP);
  localparam int HEADS = 256;
  localparam logic [LW-1:0] NIL = LW'(MAX_NODES);

  typedef enum logic [19:0] {
    S_CLR      = 20'h00001,
    S_IDLE     = 20'h00002,
    S_AL_LEAF  = 20'h00004,
    S_AL_LEAF2 = 20'h00008,
    S_AL_HEAD  = 20'h00010,
    S_AL_NODE  = 20'h00020,
    S_AL_TAKE  = 20'h00040,
    S_FR_CHK   = 20'h00080,
    S_FR_P     = 20'h00100,
    S_FR_Q     = 20'h00200,
    S_FR_QD    = 20'h00400,
    S_FR_FILE  = 20'h00800,
    S_UF_LINK  = 20'h01000,
    S_UF_HEAD  = 20'h02000,
    S_FB_CODE  = 20'h04000,
    S_FB_HEAD  = 20'h08000,
    S_FB_WRITE = 20'h10000,
    S_FB_FIX1  = 20'h20000,
    S_FB_FIX2  = 20'h40000,
    S_DONE     = 20'h80000
  } state_t;

  state_t state, ret_state;

  logic [CW-1:0]       idx;
  logic                report;
  logic [UNIT_W-1:0]   pool_size, pool_latch;
  logic [NW-1:0]       stack_top;
  logic [7:0]          leaf_mask [TOP_BINS];
  logic [TOP_BINS-1:0] top_mask;
  logic [UNIT_W-1:0]   free_units;
  logic [UNIT_W-1:0]   req, off_r, size_r, csz, coff, usize;
  logic [BIN_W-1:0]    bin;
  logic [NW-1:0]       nreg, mreg;
  logic [LW-1:0]       p, q, lp, ln, ux, uprev, unext, hreg;
  logic [STAT_W-1:0]   res_status;
  logic [UNIT_W-1:0]   res_off;
  logic [HANDLE_W-1:0] res_hnd;
  logic                out_valid;
  logic [STAT_W-1:0]   out_status;
  logic [UNIT_W-1:0]   out_off, out_total;
  logic [HANDLE_W-1:0] out_hnd;

  // RAM ports
  logic [NW-1:0]     node_ra;
  logic [BIN_W-1:0]  head_ra;
  logic [NW-1:0]     stack_ra;
  logic              off_we, size_we, bprev_we, bnext_we, nprev_we, nnext_we, use_we;
  logic              head_we, stack_we;
  logic [NW-1:0]     off_wa, size_wa, bprev_wa, bnext_wa, nprev_wa, nnext_wa, use_wa;
  logic [NW-1:0]     stack_wa;
  logic [BIN_W-1:0]  head_wa;
  logic [UNIT_W-1:0] off_wd, size_wd;
  logic [LW-1:0]     bprev_wd, bnext_wd, nprev_wd, nnext_wd, head_wd;
  logic              use_wd;
  logic [NW-1:0]     stack_wd;
  logic [UNIT_W-1:0] off_rd, size_rd;
  logic [LW-1:0]     bprev_rd, bnext_rd, nprev_rd, nnext_rd, head_rd;
  logic              use_rd;
  logic [NW-1:0]     stack_rd;

  logic [UNIT_W-1:0] code_arg;
  logic              code_up;
  logic [BIN_W-1:0]  code_val;
  logic [7:0]        lm_sel, lm_lo, lm_clr;
  logic [TOP_BINS-1:0] tm_hi;
  logic              push_ok;
  logic              in_acc;
  logic              clr_node_ok, clr_head_ok;

  function automatic logic is_node(input logic [LW-1:0] v);
    return v < NIL;
  endfunction

  function automatic logic [2:0] low8(input logic [7:0] v);
    logic [2:0] r;
    r = '0;
    for (int i = 7; i >= 0; i--) begin
      if (v[i]) r = 3'(i);
    end
    return r;
  endfunction

  function automatic logic [4:0] low32(input logic [TOP_BINS-1:0] v);
    logic [4:0] r;
    r = '0;
    for (int i = TOP_BINS - 1; i >= 0; i--) begin
      if (v[i]) r = 5'(i);
    end
    return r;
  endfunction

  assign in_acc      = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state == S_IDLE);

  assign out_ch.valid        = out_valid;
  assign out_ch.status       = out_status;
  assign out_ch.offset       = out_off;
  assign out_ch.alloc_handle = out_hnd;
  assign out_ch.free_total   = out_total;

  assign code_val    = code_of(code_arg, code_up);
  assign lm_sel      = leaf_mask[bin[7:3]];
  assign lm_lo       = lm_sel & ~((8'd1 << bin[2:0]) - 8'd1);
  assign lm_clr      = lm_sel & ~(8'd1 << bin[2:0]);
  assign push_ok     = ({1'b0, stack_top} + LW'(1)) < NIL;
  assign clr_node_ok = 32'(idx) < MAX_NODES;
  assign clr_head_ok = 32'(idx) < HEADS;

  always_comb begin
    for (int i = 0; i < TOP_BINS; i++) begin
      tm_hi[i] = top_mask[i] && (5'(i) > bin[7:3]);
    end
  end

  always_comb begin
    code_arg = csz;
    code_up  = 1'b0;
    case (state)
      S_IDLE: begin
        code_arg = in_ch.req_size;
        code_up  = 1'b1;
      end
      S_UF_LINK: code_arg = usize;
      default: code_arg = csz;
    endcase
  end

  always_comb begin
    node_ra  = nreg;
    head_ra  = bin;
    stack_ra = stack_top;
    off_we = 1'b0; size_we = 1'b0; bprev_we = 1'b0; bnext_we = 1'b0;
    nprev_we = 1'b0; nnext_we = 1'b0; use_we = 1'b0; head_we = 1'b0; stack_we = 1'b0;
    off_wa = mreg; size_wa = mreg; bprev_wa = mreg; bnext_wa = mreg;
    nprev_wa = mreg; nnext_wa = mreg; use_wa = mreg; stack_wa = stack_top + NW'(1);
    head_wa = bin;
    off_wd = coff; size_wd = csz; bprev_wd = NIL; bnext_wd = NIL;
    nprev_wd = NIL; nnext_wd = NIL; use_wd = 1'b0; head_wd = NIL; stack_wd = nreg;
    case (state)
      S_CLR: begin
        off_we = clr_node_ok; size_we = clr_node_ok; bprev_we = clr_node_ok;
        bnext_we = clr_node_ok; nprev_we = clr_node_ok; nnext_we = clr_node_ok;
        use_we = clr_node_ok; stack_we = clr_node_ok; head_we = clr_head_ok;
        off_wa = idx[NW-1:0]; size_wa = idx[NW-1:0]; bprev_wa = idx[NW-1:0];
        bnext_wa = idx[NW-1:0]; nprev_wa = idx[NW-1:0]; nnext_wa = idx[NW-1:0];
        use_wa = idx[NW-1:0]; stack_wa = idx[NW-1:0]; head_wa = idx[BIN_W-1:0];
        off_wd = '0; size_wd = '0;
        stack_wd = NW'(MAX_NODES - 1) - idx[NW-1:0];
      end
      S_IDLE: node_ra = NW'(in_ch.handle);
      S_AL_NODE: node_ra = head_rd[NW-1:0];
      S_AL_TAKE: begin
        size_we = 1'b1; size_wa = nreg; size_wd = req;
        use_we = 1'b1; use_wa = nreg; use_wd = 1'b1;
        head_we = 1'b1; head_wd = bnext_rd;
        bprev_we = is_node(bnext_rd); bprev_wa = bnext_rd[NW-1:0]; bprev_wd = NIL;
      end
      S_FR_CHK: node_ra = nprev_rd[NW-1:0];
      S_FR_Q: node_ra = q[NW-1:0];
      S_UF_LINK: begin
        if (is_node(uprev)) begin
          bnext_we = 1'b1; bnext_wa = uprev[NW-1:0]; bnext_wd = unext;
          bprev_we = is_node(unext); bprev_wa = unext[NW-1:0]; bprev_wd = uprev;
          stack_we = push_ok; stack_wd = ux[NW-1:0];
        end
      end
      S_UF_HEAD: begin
        head_we = 1'b1; head_wd = unext;
        bprev_we = is_node(unext); bprev_wa = unext[NW-1:0]; bprev_wd = NIL;
        stack_we = push_ok; stack_wd = ux[NW-1:0];
      end
      S_FR_FILE: begin
        use_we = 1'b1; use_wa = nreg; use_wd = 1'b0;
        stack_we = push_ok; stack_wd = nreg;
      end
      S_FB_WRITE: begin
        off_we = 1'b1; size_we = 1'b1; bprev_we = 1'b1; bnext_we = 1'b1;
        nprev_we = 1'b1; nnext_we = 1'b1; use_we = 1'b1; head_we = 1'b1;
        off_wa = stack_rd; size_wa = stack_rd; bprev_wa = stack_rd; bnext_wa = stack_rd;
        nprev_wa = stack_rd; nnext_wa = stack_rd; use_wa = stack_rd;
        bnext_wd = head_rd; nprev_wd = lp; nnext_wd = ln; use_wd = 1'b0;
        head_wd = {1'b0, stack_rd};
      end
      S_FB_FIX1: begin
        bprev_we = is_node(hreg); bprev_wa = hreg[NW-1:0]; bprev_wd = {1'b0, mreg};
        nprev_we = is_node(ln); nprev_wa = ln[NW-1:0]; nprev_wd = {1'b0, mreg};
      end
      S_FB_FIX2: begin
        nnext_we = is_node(lp); nnext_wa = lp[NW-1:0]; nnext_wd = {1'b0, mreg};
      end
      default: node_ra = nreg;
    endcase
  end

  sfoa_ram #(.WIDTH(UNIT_W), .DEPTH(MAX_NODES)) u_off_ram (
    .clk, .we(off_we), .waddr(off_wa), .wdata(off_wd), .raddr(node_ra), .rdata(off_rd));
  sfoa_ram #(.WIDTH(UNIT_W), .DEPTH(MAX_NODES)) u_size_ram (
    .clk, .we(size_we), .waddr(size_wa), .wdata(size_wd), .raddr(node_ra), .rdata(size_rd));
  sfoa_ram #(.WIDTH(LW), .DEPTH(MAX_NODES)) u_bprev_ram (
    .clk, .we(bprev_we), .waddr(bprev_wa), .wdata(bprev_wd), .raddr(node_ra),
    .rdata(bprev_rd));
  sfoa_ram #(.WIDTH(LW), .DEPTH(MAX_NODES)) u_bnext_ram (
    .clk, .we(bnext_we), .waddr(bnext_wa), .wdata(bnext_wd), .raddr(node_ra),
    .rdata(bnext_rd));
  sfoa_ram #(.WIDTH(LW), .DEPTH(MAX_NODES)) u_nprev_ram (
    .clk, .we(nprev_we), .waddr(nprev_wa), .wdata(nprev_wd), .raddr(node_ra),
    .rdata(nprev_rd));
  sfoa_ram #(.WIDTH(LW), .DEPTH(MAX_NODES)) u_nnext_ram (
    .clk, .we(nnext_we), .waddr(nnext_wa), .wdata(nnext_wd), .raddr(node_ra),
    .rdata(nnext_rd));
  sfoa_ram #(.WIDTH(1), .DEPTH(MAX_NODES)) u_use_ram (
    .clk, .we(use_we), .waddr(use_wa), .wdata(use_wd), .raddr(node_ra), .rdata(use_rd));
  sfoa_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_stack_ram (
    .clk, .we(stack_we), .waddr(stack_wa), .wdata(stack_wd), .raddr(stack_ra),
    .rdata(stack_rd));
  sfoa_ram #(.WIDTH(LW), .DEPTH(HEADS)) u_head_ram (
    .clk, .we(head_we), .waddr(head_wa), .wdata(head_wd), .raddr(head_ra), .rdata(head_rd));

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLR;
      ret_state  <= S_IDLE;
      idx        <= '0;
      report     <= 1'b0;
      pool_size  <= POOL_RESET;
      pool_latch <= POOL_RESET;
      stack_top  <= '0;
      top_mask   <= '0;
      for (int i = 0; i < TOP_BINS; i++) leaf_mask[i] <= '0;
      free_units <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) pool_size <= cfg_data;
      if (out_valid && out_ch.ready) out_valid <= 1'b0;
      case (state)
        S_CLR: begin
          idx <= idx + CW'(1);
          if (idx == CW'(SWEEP - 1)) begin
            stack_top <= NW'(MAX_NODES - 1);
            csz       <= pool_latch;
            coff      <= '0;
            lp        <= NIL;
            ln        <= NIL;
            state     <= S_FB_CODE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            res_status <= ST_OK;
            res_off    <= '0;
            res_hnd    <= '0;
            report     <= 1'b1;
            case (in_ch.opcode)
              OP_ALLOC: begin
                req <= in_ch.req_size;
                bin <= code_val;
                if (stack_top == '0) begin
                  res_status <= ST_NO_NODES;
                  state      <= S_DONE;
                end else begin
                  state <= S_AL_LEAF;
                end
              end
              OP_FREE: begin
                nreg <= NW'(in_ch.handle);
                if (32'(in_ch.handle) < MAX_NODES) state <= S_FR_CHK;
                else state <= S_DONE;
              end
              OP_REINIT: begin
                pool_latch <= pool_size;
                report     <= 1'b1;
                idx        <= '0;
                top_mask   <= '0;
                for (int i = 0; i < TOP_BINS; i++) leaf_mask[i] <= '0;
                free_units <= '0;
                state      <= S_CLR;
              end
              default: state <= S_DONE;
            endcase
          end
        end
        S_AL_LEAF: begin
          if (top_mask[bin[7:3]] && (lm_lo != 8'd0)) begin
            bin[2:0] <= low8(lm_lo);
            state    <= S_AL_HEAD;
          end else if (tm_hi == '0) begin
            res_status <= ST_NO_SPACE;
            state      <= S_DONE;
          end else begin
            bin[7:3] <= low32(tm_hi);
            state    <= S_AL_LEAF2;
          end
        end
        S_AL_LEAF2: begin
          if (lm_sel == 8'd0) begin
            res_status <= ST_NO_SPACE;
            state      <= S_DONE;
          end else begin
            bin[2:0] <= low8(lm_sel);
            state    <= S_AL_HEAD;
          end
        end
        S_AL_HEAD: state <= S_AL_NODE;
        S_AL_NODE: begin
          if (!is_node(head_rd)) begin
            res_status <= ST_NO_SPACE;
            state      <= S_DONE;
          end else begin
            nreg  <= head_rd[NW-1:0];
            state <= S_AL_TAKE;
          end
        end
        S_AL_TAKE: begin
          free_units <= free_units - size_rd;
          if (!is_node(bnext_rd)) begin
            leaf_mask[bin[7:3]] <= lm_clr;
            if (lm_clr == 8'd0) top_mask[bin[7:3]] <= 1'b0;
          end
          res_off <= off_rd;
          res_hnd <= HANDLE_W'(nreg);
          csz     <= size_rd - req;
          coff    <= off_rd + req;
          lp      <= {1'b0, nreg};
          ln      <= nnext_rd;
          if (size_rd == req) state <= S_DONE;
          else state <= S_FB_CODE;
        end
        S_FR_CHK: begin
          if (!use_rd) begin
            state <= S_DONE;
          end else begin
            off_r  <= off_rd;
            size_r <= size_rd;
            p      <= nprev_rd;
            q      <= nnext_rd;
            state  <= S_FR_P;
          end
        end
        S_FR_P: begin
          if (is_node(p) && !use_rd) begin
            off_r     <= off_rd;
            size_r    <= size_r + size_rd;
            lp        <= nprev_rd;
            ux        <= p;
            uprev     <= bprev_rd;
            unext     <= bnext_rd;
            usize     <= size_rd;
            ret_state <= S_FR_Q;
            state     <= S_UF_LINK;
          end else begin
            lp    <= p;
            state <= S_FR_Q;
          end
        end
        S_FR_Q: state <= S_FR_QD;
        S_FR_QD: begin
          if (is_node(q) && !use_rd) begin
            size_r    <= size_r + size_rd;
            ln        <= nnext_rd;
            ux        <= q;
            uprev     <= bprev_rd;
            unext     <= bnext_rd;
            usize     <= size_rd;
            ret_state <= S_FR_FILE;
            state     <= S_UF_LINK;
          end else begin
            ln    <= q;
            state <= S_FR_FILE;
          end
        end
        S_UF_LINK: begin
          if (is_node(uprev)) begin
            if (push_ok) stack_top <= stack_top + NW'(1);
            free_units <= free_units - usize;
            state      <= ret_state;
          end else begin
            bin   <= code_val;
            state <= S_UF_HEAD;
          end
        end
        S_UF_HEAD: begin
          if (!is_node(unext)) begin
            leaf_mask[bin[7:3]] <= lm_clr;
            if (lm_clr == 8'd0) top_mask[bin[7:3]] <= 1'b0;
          end
          if (push_ok) stack_top <= stack_top + NW'(1);
          free_units <= free_units - usize;
          state      <= ret_state;
        end
        S_FR_FILE: begin
          if (push_ok) stack_top <= stack_top + NW'(1);
          csz   <= size_r;
          coff  <= off_r;
          state <= S_FB_CODE;
        end
        S_FB_CODE: begin
          bin   <= code_val;
          state <= S_FB_HEAD;
        end
        S_FB_HEAD: state <= S_FB_WRITE;
        S_FB_WRITE: begin
          if (stack_top != '0) stack_top <= stack_top - NW'(1);
          if (!is_node(head_rd)) begin
            leaf_mask[bin[7:3]] <= lm_sel | (8'd1 << bin[2:0]);
            top_mask[bin[7:3]]  <= 1'b1;
          end
          free_units <= free_units + csz;
          hreg       <= head_rd;
          mreg       <= stack_rd;
          state      <= S_FB_FIX1;
        end
        S_FB_FIX1: state <= S_FB_FIX2;
        S_FB_FIX2: begin
          if (report) state <= S_DONE;
          else state <= S_IDLE;
        end
        S_DONE: begin
          if (!out_valid || out_ch.ready) begin
            out_valid  <= 1'b1;
            out_status <= res_status;
            out_off    <= res_off;
            out_hnd    <= res_hnd;
            out_total  <= free_units;
            report     <= 1'b1;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

>>> design/sfoa_checker.sv
// Port-level checker of the offset allocator and its bind.
`include "segregated_fit_offset_allocator_macros.svh"

module sfoa_checker import sfoa_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [STAT_W-1:0]   status,
  input logic [UNIT_W-1:0]   offset,
  input logic [HANDLE_W-1:0] alloc_handle
);
  `SFOA_ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)
  `SFOA_ASSERT_IMP(a_status_code, clk, rst, out_valid, status != ST_UNUSED)
  `SFOA_ASSERT_IMP(a_fail_zero, clk, rst, out_valid && (status != ST_OK),
                   (offset == '0) && (alloc_handle == '0))
  `SFOA_ASSERT_NXT(a_busy_after_beat, clk, rst, in_valid && in_ready, !in_ready)
endmodule

bind segregated_fit_offset_allocator sfoa_checker u_sfoa_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .status       (out_ch.status),
  .offset       (out_ch.offset),
  .alloc_handle (out_ch.alloc_handle)
);

>>> tb/sv/segregated_fit_offset_allocator_tb.sv
// Testbench for the segregated-fit offset allocator: directed and random traffic checked beat by beat.
module segregated_fit_offset_allocator_tb;
  import sfoa_pkg::*;

  localparam int unsigned NODES = 1024;
  localparam int unsigned NIL   = NODES;

  typedef struct packed {
    status_t             status;
    logic [UNIT_W-1:0]   offset;
    logic [HANDLE_W-1:0] alloc_handle;
    logic [UNIT_W-1:0]   free_total;
  } grant_t;

  class alloc_scoreboard;
    int unsigned pool;
    int unsigned blk_off[NODES];
    int unsigned blk_size[NODES];
    int unsigned bin_prev[NODES];
    int unsigned bin_next[NODES];
    int unsigned adj_prev[NODES];
    int unsigned adj_next[NODES];
    bit          busy[NODES];
    int unsigned spare[NODES];
    int unsigned spare_top;
    int unsigned bin_first[256];
    logic [7:0]  leaf_bits[32];
    logic [31:0] top_bits;
    int unsigned free_units;
    grant_t      expected_grants[$];

    function new();
      pool = POOL_RESET;
      rebuild();
    endfunction

    function int unsigned size_class(logic [31:0] size, bit up);
      int unsigned hb;
      int unsigned start;
      int unsigned mant;
      if (size < 8) return size;
      hb = 0;
      for (int i = 0; i < 32; i++) if (size[i]) hb = i;
      start = hb - 3;
      mant = (size >> start) & 7;
      if (up && ((size & ((32'd1 << start) - 32'd1)) != 0)) mant++;
      return ((start + 1) << 3) + mant;
    endfunction

    function int unsigned lowest_set(logic [31:0] v);
      if (v == 0) return 32;
      for (int i = 0; i < 32; i++) if (v[i]) return i;
      return 32;
    endfunction

    function int unsigned first_from(logic [31:0] mask, int unsigned start);
      if (start > 31) return 32;
      return lowest_set(mask & ~((32'd1 << start) - 32'd1));
    endfunction

    function void clear_bin_bits(int unsigned bin);
      int unsigned t;
      t = (bin >> 3) & 31;
      leaf_bits[t][bin & 7] = 1'b0;
      if (leaf_bits[t] == 0) top_bits[t] = 1'b0;
    endfunction

    function void push_spare(int unsigned n);
      if (spare_top + 1 < NODES) begin
        spare_top++;
        spare[spare_top] = n;
      end
    endfunction

    function int unsigned pop_spare();
      int unsigned n;
      n = spare[spare_top % NODES];
      if (spare_top > 0) spare_top--;
      return (n < NODES) ? n : 0;
    endfunction

    function int unsigned file_block(int unsigned size, int unsigned off);
      int unsigned bin;
      int unsigned h;
      int unsigned n;
      bin = size_class(size, 0) & 255;
      h = bin_first[bin];
      if (h >= NODES) begin
        leaf_bits[bin >> 3][bin & 7] = 1'b1;
        top_bits[bin >> 3] = 1'b1;
      end
      n = pop_spare();
      blk_off[n] = off;
      blk_size[n] = size;
      bin_prev[n] = NIL;
      bin_next[n] = h;
      adj_prev[n] = NIL;
      adj_next[n] = NIL;
      busy[n] = 0;
      if (h < NODES) bin_prev[h] = n;
      bin_first[bin] = n;
      free_units += size;
      return n;
    endfunction

    function void unfile_block(int unsigned n);
      int unsigned p;
      int unsigned q;
      int unsigned bin;
      p = bin_prev[n];
      q = bin_next[n];
      if (p < NODES) begin
        bin_next[p] = q;
        if (q < NODES) bin_prev[q] = p;
      end else begin
        bin = size_class(blk_size[n], 0) & 255;
        bin_first[bin] = q;
        if (q < NODES) bin_prev[q] = NIL;
        else clear_bin_bits(bin);
      end
      push_spare(n);
      free_units -= blk_size[n];
    endfunction

    function void rebuild();
      free_units = 0;
      top_bits = 0;
      foreach (leaf_bits[i]) leaf_bits[i] = 0;
      foreach (bin_first[i]) bin_first[i] = NIL;
      for (int unsigned i = 0; i < NODES; i++) begin
        blk_off[i] = 0;
        blk_size[i] = 0;
        bin_prev[i] = NIL;
        bin_next[i] = NIL;
        adj_prev[i] = NIL;
        adj_next[i] = NIL;
        busy[i] = 0;
        spare[i] = NODES - 1 - i;
      end
      spare_top = NODES - 1;
      void'(file_block(pool, 0));
    endfunction

    function status_t allocate(int unsigned size, output int unsigned off,
                               output int unsigned hnd);
      int unsigned min_bin, min_top, top, leaf, bin, n, total, nxt, rest, m, nn;
      off = 0;
      hnd = 0;
      if (spare_top == 0) return ST_NO_NODES;
      min_bin = size_class(size, 1);
      min_top = min_bin >> 3;
      top = min_top;
      leaf = 32;
      if (min_top < 32 && top_bits[min_top])
        leaf = first_from({24'd0, leaf_bits[min_top]}, min_bin & 7);
      if (leaf == 32) begin
        top = first_from(top_bits, min_top + 1);
        if (top == 32) return ST_NO_SPACE;
        leaf = lowest_set({24'd0, leaf_bits[top]});
        if (leaf == 32) return ST_NO_SPACE;
      end
      bin = ((top << 3) | leaf) & 255;
      n = bin_first[bin];
      if (n >= NODES) return ST_NO_SPACE;
      total = blk_size[n];
      blk_size[n] = size;
      busy[n] = 1;
      nxt = bin_next[n];
      bin_first[bin] = nxt;
      if (nxt < NODES) bin_prev[nxt] = NIL;
      free_units -= total;
      if (nxt >= NODES) clear_bin_bits(bin);
      rest = total - size;
      if (rest > 0) begin
        m = file_block(rest, blk_off[n] + size);
        nn = adj_next[n];
        if (nn < NODES) adj_prev[nn] = m;
        adj_prev[m] = n;
        adj_next[m] = nn;
        adj_next[n] = m;
      end
      off = blk_off[n];
      hnd = n;
      return ST_OK;
    endfunction

    function void release_node(int unsigned n);
      int unsigned off, size, p, q, m;
      if (n >= NODES || !busy[n]) return;
      off = blk_off[n];
      size = blk_size[n];
      p = adj_prev[n];
      if (p < NODES && !busy[p]) begin
        off = blk_off[p];
        size += blk_size[p];
        unfile_block(p);
        adj_prev[n] = adj_prev[p];
      end
      q = adj_next[n];
      if (q < NODES && !busy[q]) begin
        size += blk_size[q];
        unfile_block(q);
        adj_next[n] = adj_next[q];
      end
      q = adj_next[n];
      p = adj_prev[n];
      busy[n] = 0;
      push_spare(n);
      m = file_block(size, off);
      if (q < NODES) begin
        adj_next[m] = q;
        adj_prev[q] = m;
      end
      if (p < NODES) begin
        adj_prev[m] = p;
        adj_next[p] = m;
      end
    endfunction

    function grant_t note_request(opcode_t op, logic [31:0] size, logic [9:0] hnd);
      grant_t g;
      int unsigned off;
      int unsigned h;
      g = '0;
      g.status = ST_OK;
      case (op)
        OP_ALLOC: begin
          g.status = allocate(size, off, h);
          g.offset = off;
          g.alloc_handle = h[9:0];
        end
        OP_FREE: release_node(hnd);
        OP_REINIT: rebuild();
        default: ;
      endcase
      g.free_total = free_units;
      expected_grants.push_back(g);
      return g;
    endfunction

    function string check_grant(grant_t got);
      grant_t e;
      if (expected_grants.size() == 0) return "result beat with nothing pending";
      e = expected_grants.pop_front();
      if (got !== e)
        return $sformatf("got st=%0d off=%0h hnd=%0d free=%0h, want st=%0d off=%0h hnd=%0d free=%0h",
                         got.status, got.offset, got.alloc_handle, got.free_total,
                         e.status, e.offset, e.alloc_handle, e.free_total);
      return "";
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [UNIT_W-1:0] cfg_data = '0;

  sfoa_in_if  in_ch();
  sfoa_out_if out_ch();

  segregated_fit_offset_allocator uut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  alloc_scoreboard sb = new();
  int errors = 0;
  int hold_off = 0;
  bit quiet_phase = 0;
  logic [9:0] live[$];

  always #2 clk = ~clk;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.opcode = OP_NONE;
    in_ch.req_size = '0;
    in_ch.handle = '0;
    out_ch.ready = 1'b0;
  end

  task automatic report(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet_phase || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_request(opcode_t op, logic [31:0] size, logic [9:0] hnd);
    grant_t g;
    int gap;
    in_ch.valid <= 1'b1;
    in_ch.opcode <= op;
    in_ch.req_size <= size;
    in_ch.handle <= hnd;
    do @(posedge clk); while (!in_ch.ready);
    g = sb.note_request(op, size, hnd);
    if (op == OP_ALLOC && g.status == ST_OK) live.push_back(g.alloc_handle);
    if (op == OP_FREE)
      for (int i = live.size() - 1; i >= 0; i--) if (live[i] == hnd) live.delete(i);
    if (op == OP_REINIT) live.delete();
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.expected_grants.size() != 0) @(posedge clk);
  endtask

  task automatic write_pool_size(logic [31:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.pool = v;
  endtask

  task automatic free_live(int idx);
    send_request(OP_FREE, $urandom, live[idx]);
  endtask

  function automatic logic [31:0] pick_size(int unsigned pool);
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return $urandom_range(0, 64);
    if (r < 80) return $urandom_range(0, (pool >> 6) + 1);
    return $urandom >> $urandom_range(0, 31);
  endfunction

  task automatic random_phase(int n, int alloc_pct, bit tiny);
    int r;
    logic [9:0] stale;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < alloc_pct || live.size() == 0 && r < 90)
        send_request(OP_ALLOC, tiny ? $urandom_range(1, 3) : pick_size(sb.pool),
                     10'($urandom));
      else if (r < 90)
        free_live($urandom_range(0, live.size() - 1));
      else if (r < 95) begin
        stale = 10'($urandom);
        send_request(OP_FREE, $urandom, stale);
      end else if (r < 99)
        send_request(OP_NONE, $urandom, 10'($urandom));
      else if (!tiny)
        send_request(OP_REINIT, $urandom, 10'($urandom));
    end
  endtask

  initial begin
    logic [9:0] old;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    send_request(OP_ALLOC, 0, 0);
    send_request(OP_ALLOC, 1, 0);
    send_request(OP_ALLOC, 7, 0);
    send_request(OP_ALLOC, 8, 0);
    send_request(OP_ALLOC, 9, 0);
    send_request(OP_ALLOC, 32'hffffffff, 0);
    old = live[1];
    send_request(OP_FREE, 0, old);
    send_request(OP_FREE, 0, old);
    send_request(OP_FREE, 0, 10'd1023);
    send_request(OP_NONE, 32'hffffffff, 10'h3ff);
    send_request(OP_ALLOC, 1000, 0);
    old = live[0];
    send_request(OP_REINIT, 0, 0);
    send_request(OP_FREE, 0, old);
    send_request(OP_ALLOC, POOL_RESET, 0);
    send_request(OP_ALLOC, 1, 0);
    write_pool_size(0);
    send_request(OP_REINIT, 0, 0);
    send_request(OP_ALLOC, 0, 0);
    send_request(OP_ALLOC, 1, 0);
    write_pool_size(32'hffffffff);
    send_request(OP_REINIT, 0, 0);
    send_request(OP_ALLOC, 32'hffffffff, 0);
    send_request(OP_ALLOC, 0, 0);

    write_pool_size(POOL_RESET);
    send_request(OP_REINIT, 0, 0);
    random_phase(60, 55, 0);
    hold_off = 400;
    random_phase(150, 55, 0);
    drain();
    quiet_phase = 1;
    random_phase(80, 60, 0);
    quiet_phase = 0;
    write_pool_size(32'hffffffff);
    send_request(OP_REINIT, 0, 0);
    random_phase(100, 60, 0);
    write_pool_size(1000);
    send_request(OP_REINIT, 0, 0);
    random_phase(100, 60, 0);
    write_pool_size(37);
    send_request(OP_REINIT, 0, 0);
    random_phase(80, 55, 0);
    write_pool_size(POOL_RESET);
    send_request(OP_REINIT, 0, 0);
    random_phase(200, 95, 1);

    drain();
    repeat (50) @(posedge clk);
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin
    grant_t got;
    string msg;
    int r;
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        got.status = status_t'(out_ch.status);
        got.offset = out_ch.offset;
        got.alloc_handle = out_ch.alloc_handle;
        got.free_total = out_ch.free_total;
        msg = sb.check_grant(got);
        if (msg != "") report(msg);
      end
      if (hold_off > 0) begin
        hold_off--;
        out_ch.ready <= 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (quiet_phase || r < 65) out_ch.ready <= 1'b1;
        else if (r < 97) out_ch.ready <= 1'b0;
        else hold_off = $urandom_range(10, 40);
      end
    end
  end

  initial begin
    #20000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

>>> segregated_fit_offset_allocator.f
+incdir+design
design/sfoa_pkg.sv
design/sfoa_if.sv
design/sfoa_ram.sv
design/segregated_fit_offset_allocator.sv
design/sfoa_checker.sv
tb/sv/segregated_fit_offset_allocator_tb.sv
